// ===== src/ffsa_pkg.sv =====
package ffsa_pkg;

  localparam int MAX_SLOTS = 256;
  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int GRP_W = 16;
  localparam int GRP_BIT_W = $clog2(GRP_W);
  localparam int NUM_GRP = (MAX_SLOTS + GRP_W - 1) / GRP_W;
  localparam int GRP_IDX_W = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
  localparam int PAD_SLOTS = NUM_GRP * GRP_W;

  localparam int CNT_W = 9;
  localparam int STRIDE_W = 16;
  localparam int ADDR_W = 64;
  localparam int OFS_W = IDX_W + STRIDE_W;
  localparam int REL_W = 8;
  localparam int SLOT_W = 8;
  localparam int STATUS_W = 2;

  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;

  localparam logic [2:0] REG_ENTRIES = 3'd0;
  localparam logic [2:0] REG_CPU_BASE = 3'd1;
  localparam logic [2:0] REG_GPU_BASE = 3'd2;
  localparam logic [2:0] REG_STRIDE = 3'd3;
  localparam logic [2:0] REG_VISIBLE = 3'd4;

  localparam logic [CNT_W-1:0] ENTRIES_RESET = 9'd256;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd32;

  localparam logic OP_ALLOCATE = 1'b0;
  localparam logic OP_FREE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PICK,
    S_MUL,
    S_ADD
  } state_t;

  typedef struct packed {
    logic load;
    logic pick;
    logic mul;
    logic add;
  } dp_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] entries_in_use;
    logic [ADDR_W-1:0] cpu_base;
    logic [ADDR_W-1:0] gpu_base;
    logic [STRIDE_W-1:0] slot_stride;
    logic shader_visible;
  } cfg_t;

endpackage

// ===== src/ffsa_regs.sv =====
module ffsa_regs
  import ffsa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output cfg_t cfg
);

  logic wr_en;
  logic [2:0] reg_sel;

  assign wr_en = psel && penable && pwrite;
  assign reg_sel = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.entries_in_use <= ENTRIES_RESET;
      cfg.cpu_base <= '0;
      cfg.gpu_base <= '0;
      cfg.slot_stride <= STRIDE_RESET;
      cfg.shader_visible <= 1'b0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_ENTRIES: cfg.entries_in_use <= pwdata[CNT_W-1:0];
        REG_CPU_BASE: cfg.cpu_base <= pwdata;
        REG_GPU_BASE: cfg.gpu_base <= pwdata;
        REG_STRIDE: cfg.slot_stride <= pwdata[STRIDE_W-1:0];
        REG_VISIBLE: cfg.shader_visible <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ENTRIES: prdata = PDATA_W'(cfg.entries_in_use);
      REG_CPU_BASE: prdata = cfg.cpu_base;
      REG_GPU_BASE: prdata = cfg.gpu_base;
      REG_STRIDE: prdata = PDATA_W'(cfg.slot_stride);
      REG_VISIBLE: prdata = PDATA_W'(cfg.shader_visible);
      default: prdata = '0;
    endcase
  end

endmodule

// ===== src/ffsa_ctrl.sv =====
module ffsa_ctrl
  import ffsa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output logic done,
  output dp_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == S_ADD);
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        cmd.pick = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== src/ffsa_dp.sv =====
module ffsa_dp
  import ffsa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  dp_cmd_t cmd,
  input  cfg_t cfg,
  input  logic operation,
  input  logic [REL_W-1:0] release_index,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0] slot_index,
  output logic [ADDR_W-1:0] cpu_address,
  output logic [ADDR_W-1:0] gpu_address
);

  function automatic logic [GRP_BIT_W-1:0] first_bit(input logic [GRP_W-1:0] v);
    logic [GRP_BIT_W-1:0] r;
    r = '0;
    for (int i = GRP_W - 1; i >= 0; i--) begin
      if (v[i]) r = GRP_BIT_W'(i);
    end
    return r;
  endfunction

  function automatic logic [GRP_IDX_W-1:0] first_grp(input logic [NUM_GRP-1:0] v);
    logic [GRP_IDX_W-1:0] r;
    r = '0;
    for (int i = NUM_GRP - 1; i >= 0; i--) begin
      if (v[i]) r = GRP_IDX_W'(i);
    end
    return r;
  endfunction

  logic [MAX_SLOTS-1:0] used_map;
  logic [PAD_SLOTS-1:0] free_vec;
  logic [NUM_GRP-1:0] grp_free;
  logic op_q;
  logic [REL_W-1:0] rel_q;
  logic [GRP_IDX_W-1:0] grp_sel;
  logic [GRP_W-1:0] grp_bits;
  logic [GRP_BIT_W-1:0] bit_sel;
  logic [GRP_IDX_W+GRP_BIT_W-1:0] pick_idx;
  logic rel_ok;
  logic [IDX_W-1:0] idx_q;
  logic grant_q;
  logic [STATUS_W-1:0] status_q;
  logic [OFS_W-1:0] ofs_q;

  always_comb begin
    free_vec = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      free_vec[i] = !used_map[i] && (i < int'(cfg.entries_in_use));
    end
  end

  assign grp_sel = first_grp(grp_free);
  assign grp_bits = free_vec[grp_sel * GRP_W +: GRP_W];
  assign bit_sel = first_bit(grp_bits);
  assign pick_idx = {grp_sel, bit_sel};
  assign rel_ok = ({1'b0, rel_q} < cfg.entries_in_use) && (int'(rel_q) < MAX_SLOTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      used_map <= '0;
    end else if (cmd.pick) begin
      if (op_q == OP_ALLOCATE) begin
        if (|grp_free) used_map[IDX_W'(pick_idx)] <= 1'b1;
      end else if (rel_ok) begin
        used_map[IDX_W'(rel_q)] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= operation;
      rel_q <= release_index;
      for (int g = 0; g < NUM_GRP; g++) begin
        grp_free[g] <= |free_vec[g*GRP_W +: GRP_W];
      end
    end
    if (cmd.pick) begin
      idx_q <= IDX_W'(pick_idx);
      if (op_q == OP_ALLOCATE) begin
        grant_q <= |grp_free;
        status_q <= (|grp_free) ? ST_DONE : ST_FULL;
      end else begin
        grant_q <= 1'b0;
        status_q <= rel_ok ? ST_DONE : ST_IGNORED;
      end
    end
    if (cmd.mul) begin
      ofs_q <= OFS_W'(idx_q * cfg.slot_stride);
    end
    if (cmd.add) begin
      status <= status_q;
      slot_index <= grant_q ? SLOT_W'(idx_q) : '0;
      cpu_address <= grant_q ? cfg.cpu_base + ADDR_W'(ofs_q) : '0;
      gpu_address <= (grant_q && cfg.shader_visible) ? cfg.gpu_base + ADDR_W'(ofs_q) : '0;
    end
  end

endmodule

// ===== src/first_free_slot_allocator.sv =====
// Channel   Handshake              Payload
// request   start / busy           operation, release_index
// result    done (one-cycle)       status, slot_index, cpu_address, gpu_address
// config    psel, penable, pready  pwrite, paddr, pwdata, prdata
//
// Each item passes in order through group scan, slot pick, offset multiply
// and address add; done is high in the cycle after the add.
// A new item can be accepted in the same cycle that done is high.
// Reset clears the used map at once, so no clearing pass follows reset.
// The receiver cannot stall, so every result is shown for one cycle only.
module first_free_slot_allocator
  import ffsa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic operation,
  input  logic [REL_W-1:0] release_index,
  output logic done,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0] slot_index,
  output logic [ADDR_W-1:0] cpu_address,
  output logic [ADDR_W-1:0] gpu_address,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic pready
);

  dp_cmd_t cmd;
  cfg_t cfg;

  assign pready = 1'b1;

  ffsa_regs u_regs (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .cfg(cfg)
  );

  ffsa_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .done(done),
    .cmd(cmd)
  );

  ffsa_dp u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .cfg(cfg),
    .operation(operation),
    .release_index(release_index),
    .status(status),
    .slot_index(slot_index),
    .cpu_address(cpu_address),
    .gpu_address(gpu_address)
  );

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after accept");

  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##4 done) else $error("result not delivered in four cycles");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result shown while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");

  a_no_grant_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_DONE |-> slot_index == '0 && cpu_address == '0
      && gpu_address == '0) else $error("failed item carries an address");
`endif

endmodule

// ===== bench/first_free_slot_allocator_tb.sv =====
`timescale 1ns / 100ps

module first_free_slot_allocator_tb
  import ffsa_pkg::*;
();

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 1100;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] cpu;
    logic [ADDR_W-1:0] gpu;
  } grant_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic operation;
  logic [REL_W-1:0] release_index;
  logic done;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0] slot_index;
  logic [ADDR_W-1:0] cpu_address;
  logic [ADDR_W-1:0] gpu_address;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  cfg_t alloc_cfg;
  logic [MAX_SLOTS-1:0] slot_used;
  grant_t pending_grants_q[$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int item_count = 0;
  int checked_count = 0;
  int granted_count = 0;
  int full_count = 0;
  int ignored_count = 0;
  int reg_write_count = 0;
  int setting_count = 0;

  first_free_slot_allocator i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .release_index(release_index),
    .done(done),
    .status(status),
    .slot_index(slot_index),
    .cpu_address(cpu_address),
    .gpu_address(gpu_address),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.", cycle_count,
               pending_grants_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int effective_count();
    if (int'(alloc_cfg.entries_in_use) > MAX_SLOTS) begin
      return MAX_SLOTS;
    end
    return int'(alloc_cfg.entries_in_use);
  endfunction

  function automatic grant_t predict_grant(input logic op, input logic [REL_W-1:0] rel);
    grant_t g;
    int n;
    logic [ADDR_W-1:0] offset;
    g = '0;
    g.status = ST_DONE;
    n = effective_count();
    if (op == OP_ALLOCATE) begin
      g.status = ST_FULL;
      for (int i = 0; i < n; i++) begin
        if (!slot_used[i]) begin
          slot_used[i] = 1'b1;
          offset = ADDR_W'(i) * ADDR_W'(alloc_cfg.slot_stride);
          g.status = ST_DONE;
          g.slot = SLOT_W'(i);
          g.cpu = alloc_cfg.cpu_base + offset;
          if (alloc_cfg.shader_visible) begin
            g.gpu = alloc_cfg.gpu_base + offset;
          end
          break;
        end
      end
    end else if (int'(rel) < n) begin
      slot_used[rel] = 1'b0;
    end else begin
      g.status = ST_IGNORED;
    end
    return g;
  endfunction

  function automatic logic [PDATA_W-1:0] register_value(input logic [2:0] reg_id);
    case (reg_id)
      REG_ENTRIES: return PDATA_W'(alloc_cfg.entries_in_use);
      REG_CPU_BASE: return alloc_cfg.cpu_base;
      REG_GPU_BASE: return alloc_cfg.gpu_base;
      REG_STRIDE: return PDATA_W'(alloc_cfg.slot_stride);
      REG_VISIBLE: return PDATA_W'(alloc_cfg.shader_visible);
      default: return '0;
    endcase
  endfunction

  function automatic logic [REL_W-1:0] pick_used_slot();
    logic [REL_W-1:0] candidates[$];
    int n;
    n = effective_count();
    for (int i = 0; i < n; i++) begin
      if (slot_used[i]) begin
        candidates.push_back(REL_W'(i));
      end
    end
    if (candidates.size() == 0) begin
      return REL_W'($urandom_range(0, MAX_SLOTS - 1));
    end
    return candidates[$urandom_range(0, candidates.size() - 1)];
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] want, input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (!rst && done) begin
      if (pending_grants_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: result with no request outstanding, status %0d slot %0d", $time,
                   status, slot_index);
        end
      end else begin
        want = pending_grants_q.pop_front();
        checked_count++;
        if (status !== want.status) flag_mismatch("status", 64'(want.status), 64'(status));
        if (slot_index !== want.slot) flag_mismatch("slot_index", 64'(want.slot), 64'(slot_index));
        if (cpu_address !== want.cpu) flag_mismatch("cpu_address", want.cpu, cpu_address);
        if (gpu_address !== want.gpu) flag_mismatch("gpu_address", want.gpu, gpu_address);
      end
    end
  end

  task automatic send_item(input logic op, input logic [REL_W-1:0] rel);
    grant_t g;
    @(negedge clk);
    start <= 1'b1;
    operation <= op;
    release_index <= rel;
    do @(posedge clk); while (busy);
    g = predict_grant(op, rel);
    pending_grants_q.push_back(g);
    item_count++;
    case (g.status)
      ST_FULL: full_count++;
      ST_IGNORED: ignored_count++;
      default: if (op == OP_ALLOCATE) granted_count++;
    endcase
  endtask

  task automatic pause_sender(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_idle();
    pause_sender(1);
    while (pending_grants_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic check_register(input logic [2:0] reg_id);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= PADDR_W'({reg_id, 3'b000});
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== register_value(reg_id)) begin
      flag_mismatch($sformatf("register %0d readback", reg_id), register_value(reg_id), prdata);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] reg_id, input logic [PDATA_W-1:0] value);
    wait_idle();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({reg_id, 3'b000});
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (reg_id)
      REG_ENTRIES: alloc_cfg.entries_in_use = value[CNT_W-1:0];
      REG_CPU_BASE: alloc_cfg.cpu_base = value;
      REG_GPU_BASE: alloc_cfg.gpu_base = value;
      REG_STRIDE: alloc_cfg.slot_stride = value[STRIDE_W-1:0];
      REG_VISIBLE: alloc_cfg.shader_visible = value[0];
      default: ;
    endcase
    reg_write_count++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    check_register(reg_id);
  endtask

  task automatic test_reset_values();
    check_register(REG_ENTRIES);
    check_register(REG_CPU_BASE);
    check_register(REG_GPU_BASE);
    check_register(REG_STRIDE);
    check_register(REG_VISIBLE);
    repeat (3) send_item(OP_ALLOCATE, 8'd0);
    send_item(OP_FREE, 8'd1);
    send_item(OP_ALLOCATE, 8'd255);
  endtask

  task automatic test_small_pool();
    write_reg(REG_ENTRIES, 64'd4);
    write_reg(REG_CPU_BASE, 64'hFFFF_FFFF_FFFF_FFF0);
    write_reg(REG_GPU_BASE, 64'hFFFF_FFFF_FFFF_0000);
    write_reg(REG_STRIDE, 64'hFFFF);
    write_reg(REG_VISIBLE, 64'd1);
    send_item(OP_ALLOCATE, 8'd0);
    send_item(OP_ALLOCATE, 8'd0);
    send_item(OP_FREE, 8'd4);
    send_item(OP_FREE, 8'd255);
    send_item(OP_FREE, 8'd1);
    send_item(OP_FREE, 8'd1);
    send_item(OP_ALLOCATE, 8'd0);
  endtask

  task automatic test_count_edges();
    write_reg(REG_ENTRIES, 64'd0);
    send_item(OP_ALLOCATE, 8'd0);
    send_item(OP_FREE, 8'd0);
    write_reg(REG_ENTRIES, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_STRIDE, 64'd0);
    send_item(OP_ALLOCATE, 8'd0);
    write_reg(REG_ENTRIES, 64'd2);
    send_item(OP_FREE, 8'd3);
    send_item(OP_ALLOCATE, 8'd0);
    write_reg(REG_ENTRIES, 64'd8);
    write_reg(REG_STRIDE, 64'd1);
    write_reg(REG_VISIBLE, 64'd0);
    send_item(OP_ALLOCATE, 8'd0);
    send_item(OP_ALLOCATE, 8'd0);
  endtask

  task automatic random_settings();
    logic [63:0] junk;
    int cnt;
    junk = {$urandom, $urandom};
    case ($urandom_range(0, 19))
      0: cnt = 0;
      1, 2: cnt = MAX_SLOTS;
      3: cnt = $urandom_range(MAX_SLOTS + 1, 511);
      4: cnt = 1;
      5, 6: cnt = $urandom_range(25, MAX_SLOTS - 1);
      default: cnt = $urandom_range(2, 24);
    endcase
    write_reg(REG_ENTRIES, {junk[63:CNT_W], CNT_W'(cnt)});
    case ($urandom_range(0, 3))
      0: write_reg(REG_CPU_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
      1: write_reg(REG_CPU_BASE, 64'd0);
      default: write_reg(REG_CPU_BASE, {$urandom, $urandom});
    endcase
    case ($urandom_range(0, 3))
      0: write_reg(REG_GPU_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
      1: write_reg(REG_GPU_BASE, 64'd0);
      default: write_reg(REG_GPU_BASE, {$urandom, $urandom});
    endcase
    case ($urandom_range(0, 5))
      0: write_reg(REG_STRIDE, {junk[63:STRIDE_W], 16'd0});
      1: write_reg(REG_STRIDE, {junk[63:STRIDE_W], 16'hFFFF});
      2: write_reg(REG_STRIDE, {junk[63:STRIDE_W], 16'd1});
      default: write_reg(REG_STRIDE, {junk[63:STRIDE_W], 16'($urandom)});
    endcase
    write_reg(REG_VISIBLE, {junk[63:1], 1'($urandom)});
    setting_count++;
  endtask

  task automatic test_random_traffic();
    int sent;
    int phase_len;
    int alloc_pct;
    int burst;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      random_settings();
      phase_len = $urandom_range(30, 120);
      alloc_pct = $urandom_range(35, 75);
      while (phase_len > 0) begin
        burst = $urandom_range(1, 16);
        while (burst > 0 && phase_len > 0) begin
          if ($urandom_range(1, 100) <= alloc_pct) begin
            send_item(OP_ALLOCATE, REL_W'($urandom));
          end else if ($urandom_range(0, 3) != 0) begin
            send_item(OP_FREE, pick_used_slot());
          end else begin
            send_item(OP_FREE, REL_W'($urandom));
          end
          burst--;
          phase_len--;
          sent++;
        end
        if ($urandom_range(0, 3) != 0) begin
          pause_sender($urandom_range(1, 8));
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    operation = OP_ALLOCATE;
    release_index = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    slot_used = '0;
    alloc_cfg.entries_in_use = ENTRIES_RESET;
    alloc_cfg.cpu_base = '0;
    alloc_cfg.gpu_base = '0;
    alloc_cfg.slot_stride = STRIDE_RESET;
    alloc_cfg.shader_visible = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_small_pool();
    test_count_edges();
    test_random_traffic();

    wait_idle();
    repeat (10) @(posedge clk);
    if (pending_grants_q.size() != 0) begin
      mismatch_count += pending_grants_q.size();
    end
    $display("Sent %0d items, checked %0d results: %0d grants, %0d full, %0d ignored frees.",
             item_count, checked_count, granted_count, full_count, ignored_count);
    $display("Made %0d register writes across %0d random settings with readback.",
             reg_write_count, setting_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
